// File: rtl/core/ukt_pkg.sv
// shared types and constants of the unique key table
package ukt_pkg;

    localparam int CAPACITY = 8;
    localparam int KEY_W    = 56;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 4;
    localparam int STAT_W   = 3;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [OCC_W-1:0] occ_t;

    typedef enum logic
    {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [STAT_W-1:0]
    {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    typedef struct packed
    {
        occ_t    occupancy;
        status_t status;
    } res_t;

    typedef struct packed
    {
        logic en;
        idx_t addr;
        key_t data;
    } wr_req_t;

endpackage

// File: rtl/core/ukt_ram.sv
// single write port, single read port key memory with registered read data
module ukt_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 56
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ukt_ctrl.sv
// request sequencer: scans, appends and compacts the key memory
module ukt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ukt_pkg::kind_t   in_kind,
    input  ukt_pkg::key_t    in_plate,
    output logic             res_valid,
    input  logic             res_ready,
    output ukt_pkg::res_t    res,
    output ukt_pkg::idx_t    rd_addr,
    input  ukt_pkg::key_t    rd_data,
    output ukt_pkg::wr_req_t wr
);
    import ukt_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    idx_t    idx_reg, idx_next;
    cnt_t    count_reg, count_next;
    status_t status_reg, status_next;
    key_t    key_reg, key_next;
    kind_t   kind_reg, kind_next;
    logic    last_entry;
    logic    more_shift;
    logic    match;

    assign match      = (rd_data == key_reg);
    assign last_entry = ((cnt_t'(idx_reg) + cnt_t'(1)) == count_reg);
    assign more_shift = ((cnt_t'(idx_reg) + cnt_t'(2)) < count_reg);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        key_next    = key_reg;
        kind_next   = kind_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        rd_addr     = idx_reg;
        wr.en       = 1'b0;
        wr.addr     = idx_t'(count_reg);
        wr.data     = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next  = in_plate;
                    kind_next = in_kind;
                    idx_next  = '0;
                    if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                        if (in_kind == KIND_REMOVE)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            wr.en       = 1'b1;
                            wr.addr     = '0;
                            wr.data     = in_plate;
                            count_next  = cnt_t'(1);
                            status_next = ST_INSERTED;
                        end
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (match && kind_reg == KIND_INSERT)
                begin
                    status_next = ST_DUPLICATE;
                    state_next  = S_DONE;
                end
                else if (match)
                begin
                    if (last_entry)
                    begin
                        count_next  = count_reg - cnt_t'(1);
                        status_next = ST_REMOVED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (last_entry)
                begin
                    state_next = S_DONE;
                    if (kind_reg == KIND_REMOVE)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if (count_reg >= cnt_t'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // append after the last held entry
                        wr.en       = 1'b1;
                        count_next  = count_reg + cnt_t'(1);
                        status_next = ST_INSERTED;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + idx_t'(1);
                    state_next = S_RD;
                end
            end
            S_SH_RD:
            begin
                rd_addr    = idx_reg + idx_t'(1);
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                // move the entry above down into the hole
                wr.en    = 1'b1;
                wr.addr  = idx_reg;
                wr.data  = rd_data;
                idx_next = idx_reg + idx_t'(1);
                if (more_shift)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next  = count_reg - cnt_t'(1);
                    status_next = ST_REMOVED;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= ST_INSERTED;
            kind_reg   <= KIND_INSERT;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            kind_reg   <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign res.status    = status_reg;
    assign res.occupancy = occ_t'(count_reg);

`ifndef ASSERT_OFF
    logic append_en;
    assign append_en = wr.en && (state_reg != S_SH_WR);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(CAPACITY))
        else $error("entry count above capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        append_en |=> count_reg == $past(count_reg + cnt_t'(1)))
        else $error("append did not grow the table by one");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (cnt_t'(idx_reg) < count_reg))
        else $error("scan read beyond held entries");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_RD) |-> ((cnt_t'(idx_reg) + cnt_t'(1)) < count_reg))
        else $error("shift source beyond held entries");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("pending result changed before hand-off");
`endif

endmodule

// File: rtl/core/unique_key_table_with_compaction_unit.sv
// top level of the unique key table: stream ports, result register, memory and sequencer
// A request scans the held keys in order, each one addressed and then compared, until a match
// or the last entry; an empty table is answered without a scan. A key that is already present
// ends an insert early. A removal then compacts the entries above the removed key: the key
// memory has one read port with registered read data, so each is first read and then written
// one place down. The result enters the output register as the sequencer leaves its done
// state. Requests are handled one at a time. A new request beat is taken in the cycle after
// the previous result lands in the output register, even while that result is still waiting
// on the output side. The table starts empty after reset.
module unique_key_table_with_compaction_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [55:0] plate
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [2:0] status, [6:3] occupancy, [7] zero
);
    import ukt_pkg::*;

    logic    res_valid;
    logic    res_ready;
    res_t    res;
    idx_t    rd_addr;
    key_t    rd_data;
    wr_req_t wr;
    logic    out_valid_reg;
    res_t    out_res_reg;

    ukt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ukt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (kind_t'(s_axis_tuser)),
        .in_plate  (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr        (wr)
    );

    // output register frees the sequencer once its beat is parked here
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.occupancy, out_res_reg.status};

endmodule

// File: bench/unique_key_table_with_compaction_unit_tb.sv
// testbench of the unique key table: directed table, biased random requests, scoreboard
`timescale 1ns / 100ps

module unique_key_table_with_compaction_unit_tb;
    import ukt_pkg::*;

    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM   = 1275;
    localparam int POOL_SIZE    = 24;
    localparam int MAX_GAP      = 12;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        kind_t   kind;
        key_t    plate;
        bit      typed;
        status_t status;
        occ_t    occupancy;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // [55:0] plate
    logic        s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [2:0] status, [6:3] occupancy, [7] zero

    // shadow copy of the table, updated at every accepted request
    key_t     plate_table [CAPACITY];
    int       plate_count;
    res_t     pending_results [$];
    dir_row_t dir_rows [NUM_DIRECTED];

    int fault_count;
    int sent_count;
    int rx_count;
    int status_tally [6];

    unique_key_table_with_compaction_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic status_t apply_request(kind_t kind, key_t plate);
        int pos;
        pos = -1;
        for (int i = 0; i < plate_count; i++)
        begin
            if (pos < 0 && plate_table[i] == plate)
                pos = i;
        end
        if (kind == KIND_INSERT)
        begin
            if (pos >= 0)
                return ST_DUPLICATE;
            if (plate_count >= CAPACITY)
                return ST_FULL;
            plate_table[plate_count] = plate;
            plate_count++;
            return ST_INSERTED;
        end
        if (plate_count == 0)
            return ST_EMPTY;
        if (pos < 0)
            return ST_NOT_FOUND;
        // compaction: later entries move down one place
        for (int i = pos; i + 1 < plate_count; i++)
            plate_table[i] = plate_table[i + 1];
        plate_count--;
        return ST_REMOVED;
    endfunction

    task automatic report_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic send_request(kind_t kind, key_t plate, bit typed, status_t t_status,
                                occ_t t_occ, int gap);
        res_t predicted;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= plate;
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted.status    = apply_request(kind, plate);
        predicted.occupancy = occ_t'(plate_count);
        if (typed)
        begin
            predicted.status    = t_status;
            predicted.occupancy = t_occ;
        end
        pending_results.push_back(predicted);
        sent_count++;
    endtask

    // result side: random stalls, one long hold-off, scoreboard compare
    initial
    begin
        int   gap;
        res_t got;
        res_t want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_count == 400)
                gap = LONG_HOLD;
            else if (((rx_count / 64) % 4) == 2)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got = res_t'(m_axis_tdata[6:0]);
            rx_count++;
            if (got.status <= ST_NOT_FOUND)
                status_tally[got.status]++;
            if (pending_results.size() == 0)
                report_fault($sformatf("result status %0d occupancy %0d with nothing pending",
                                       got.status, got.occupancy));
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.occupancy != want.occupancy)
                    report_fault($sformatf("expected status %0d occupancy %0d, got %0d / %0d",
                                           want.status, want.occupancy,
                                           got.status, got.occupancy));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        key_t  key_pool [POOL_SIZE];
        key_t  plate;
        kind_t kind;
        int    gap;
        int    pick;
        int    len;
        int    insert_pct;
        int    v;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_INSERT;
        plate_count   = 0;
        fault_count   = 0;
        sent_count    = 0;
        rx_count      = 0;
        insert_pct    = 50;
        foreach (status_tally[i])
            status_tally[i] = 0;

        // directed: extremes, whole-key match, duplicate on full, compaction
        dir_rows[0]  = '{KIND_REMOVE, '0, 1'b1, ST_EMPTY, 4'd0};
        dir_rows[1]  = '{KIND_INSERT, '0, 1'b1, ST_INSERTED, 4'd1};
        dir_rows[2]  = '{KIND_INSERT, '1, 1'b1, ST_INSERTED, 4'd2};
        dir_rows[3]  = '{KIND_INSERT, '0, 1'b1, ST_DUPLICATE, 4'd2};
        dir_rows[4]  = '{KIND_INSERT, 56'h00000000004142, 1'b1, ST_INSERTED, 4'd3};
        dir_rows[5]  = '{KIND_REMOVE, 56'h01000000004142, 1'b1, ST_NOT_FOUND, 4'd3};
        dir_rows[6]  = '{KIND_INSERT, 56'h01000000004142, 1'b0, ST_INSERTED, 4'd0};
        dir_rows[7]  = '{KIND_INSERT, "ABC1234", 1'b0, ST_INSERTED, 4'd0};
        dir_rows[8]  = '{KIND_INSERT, "XYZ9876", 1'b0, ST_INSERTED, 4'd0};
        dir_rows[9]  = '{KIND_INSERT, "KLM0001", 1'b0, ST_INSERTED, 4'd0};
        dir_rows[10] = '{KIND_INSERT, "QRS5555", 1'b0, ST_INSERTED, 4'd0};
        dir_rows[11] = '{KIND_INSERT, "ZZZ0000", 1'b1, ST_FULL, 4'd8};
        dir_rows[12] = '{KIND_INSERT, '1, 1'b1, ST_DUPLICATE, 4'd8};
        dir_rows[13] = '{KIND_REMOVE, 56'h00000000004142, 1'b1, ST_REMOVED, 4'd7};
        dir_rows[14] = '{KIND_REMOVE, '1, 1'b1, ST_REMOVED, 4'd6};
        dir_rows[15] = '{KIND_INSERT, 56'h00000000004142, 1'b1, ST_INSERTED, 4'd7};
        dir_rows[16] = '{KIND_REMOVE, '0, 1'b1, ST_REMOVED, 4'd6};
        dir_rows[17] = '{KIND_REMOVE, '0, 1'b1, ST_NOT_FOUND, 4'd6};
        dir_rows[18] = '{KIND_REMOVE, "QRS5555", 1'b0, ST_REMOVED, 4'd0};
        dir_rows[19] = '{KIND_REMOVE, 56'h01000000004142, 1'b0, ST_REMOVED, 4'd0};
        dir_rows[20] = '{KIND_REMOVE, "ABC1234", 1'b0, ST_REMOVED, 4'd0};
        dir_rows[21] = '{KIND_REMOVE, "XYZ9876", 1'b0, ST_REMOVED, 4'd0};
        dir_rows[22] = '{KIND_REMOVE, "KLM0001", 1'b0, ST_REMOVED, 4'd0};
        dir_rows[23] = '{KIND_REMOVE, 56'h00000000004142, 1'b1, ST_REMOVED, 4'd0};
        dir_rows[24] = '{KIND_REMOVE, 56'h00000000004142, 1'b1, ST_EMPTY, 4'd0};

        // key pool: short ascii plates and raw 56-bit values
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i % 2 == 0)
            begin
                key_pool[i] = '0;
                len = $urandom_range(1, 7);
                for (int c = 0; c < len; c++)
                begin
                    v = $urandom_range(0, 35);
                    key_pool[i][8*c +: 8] = (v < 10) ? 8'(8'h30 + v) : 8'(8'h41 + v - 10);
                end
            end
            else
                key_pool[i] = key_t'({$urandom, $urandom});
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(dir_rows[i].kind, dir_rows[i].plate, dir_rows[i].typed,
                         dir_rows[i].status, dir_rows[i].occupancy, $urandom_range(0, MAX_GAP));

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            // phases lean toward filling, churning or draining the table
            if (n % 60 == 0)
            begin
                pick = $urandom_range(0, 2);
                insert_pct = (pick == 0) ? 80 : (pick == 1) ? 50 : 20;
            end
            if (n == 800)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            pick = $urandom_range(0, 99);
            if (kind == KIND_INSERT)
            begin
                if (pick < 70)
                    plate = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (pick < 85 && plate_count > 0)
                    plate = plate_table[$urandom_range(0, plate_count - 1)];
                else
                    plate = key_t'({$urandom, $urandom});
            end
            else
            begin
                if (pick < 55 && plate_count > 0)
                    plate = plate_table[$urandom_range(0, plate_count - 1)];
                else if (pick < 80)
                    plate = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (pick < 90 && plate_count > 0)
                    // near miss: a held key with one bit flipped
                    plate = plate_table[$urandom_range(0, plate_count - 1)]
                            ^ (key_t'(1) << $urandom_range(0, KEY_W - 1));
                else
                    plate = key_t'({$urandom, $urandom});
            end
            gap = (((n / 64) % 4) == 1) ? 0 : $urandom_range(0, MAX_GAP);
            send_request(kind, plate, 1'b0, ST_INSERTED, 4'd0, gap);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests (%0d directed, %0d random), %0d results checked",
                 sent_count, NUM_DIRECTED, NUM_RANDOM, rx_count);
        $display("outcomes: inserted %0d, duplicate %0d, full %0d, removed %0d, empty %0d, %s %0d",
                 status_tally[ST_INSERTED], status_tally[ST_DUPLICATE], status_tally[ST_FULL],
                 status_tally[ST_REMOVED], status_tally[ST_EMPTY], "not found",
                 status_tally[ST_NOT_FOUND]);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches", fault_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ukt_pkg.sv
rtl/core/ukt_ram.sv
rtl/core/ukt_ctrl.sv
rtl/core/unique_key_table_with_compaction_unit.sv
bench/unique_key_table_with_compaction_unit_tb.sv
